@@ rtl/ucb1_pkg.sv @@
// ----------------------------------------------------------------------------
// UCB1 selector package
// Shared types, constants and controller commands.
// ----------------------------------------------------------------------------
package ucb1_pkg;

    localparam int unsigned ARMS       = 16;
    localparam int unsigned ARM_BITS   = $clog2(ARMS);
    localparam int unsigned ROUND_BITS = 32;
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;
    localparam logic [4:0]  ARMS_RESET = 5'd16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD_RD,
        S_UPD_DIV,
        S_UPD_WR,
        S_LOG,
        S_LN,
        S_SCAN_RD,
        S_SCAN_DIV,
        S_SCAN_SQRT,
        S_SCAN_CMP,
        S_OUT
    } t_state;

    // phases of the log2 unit
    typedef enum logic [1:0] {
        LOG_IDLE,
        LOG_LZ,
        LOG_SQ
    } t_log_phase;

    typedef struct packed {
        logic start_upd;
        logic upd_wr;
        logic log_start;
        logic ln_calc;
        logic scan_init;
        logic scan_rd;
        logic div_start;
        logic sqrt_start;
        logic scan_cmp;
        logic scan_next;
        logic pick_next;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic log_done;
        logic explore;
        logic count_zero;
        logic scan_last;
    } t_status;

endpackage

@@ rtl/ucb1_ctrl.sv @@
// ----------------------------------------------------------------------------
// UCB1 controller
// Sequences the update, log, and per-arm scoring of one transaction.
// ----------------------------------------------------------------------------
module ucb1_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_out_stall,
    input  ucb1_pkg::t_status i_status,
    output ucb1_pkg::t_cmd    o_cmd,
    output logic              o_stall,
    output logic              o_valid
);

    ucb1_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ucb1_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            ucb1_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.start_upd = 1'b1;
                    n_state = ucb1_pkg::S_UPD_RD;
                end
            end
            ucb1_pkg::S_UPD_RD: begin
                o_cmd.div_start = 1'b1;
                n_state = ucb1_pkg::S_UPD_DIV;
            end
            ucb1_pkg::S_UPD_DIV: begin
                if (i_status.div_done) begin
                    n_state = ucb1_pkg::S_UPD_WR;
                end
            end
            ucb1_pkg::S_UPD_WR: begin
                o_cmd.upd_wr = 1'b1;
                if (i_status.explore) begin
                    n_state = ucb1_pkg::S_OUT;
                end else begin
                    o_cmd.log_start = 1'b1;
                    n_state = ucb1_pkg::S_LOG;
                end
            end
            ucb1_pkg::S_LOG: begin
                if (i_status.log_done) begin
                    n_state = ucb1_pkg::S_LN;
                end
            end
            ucb1_pkg::S_LN: begin
                o_cmd.ln_calc   = 1'b1;
                o_cmd.scan_init = 1'b1;
                n_state = ucb1_pkg::S_SCAN_RD;
            end
            ucb1_pkg::S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state = ucb1_pkg::S_SCAN_DIV;
            end
            ucb1_pkg::S_SCAN_DIV: begin
                if (i_status.count_zero) begin
                    o_cmd.pick_next = 1'b1;
                    n_state = ucb1_pkg::S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = ucb1_pkg::S_SCAN_SQRT;
                end
            end
            ucb1_pkg::S_SCAN_SQRT: begin
                if (i_status.div_done) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state = ucb1_pkg::S_SCAN_CMP;
                end
            end
            ucb1_pkg::S_SCAN_CMP: begin
                if (i_status.sqrt_done) begin
                    o_cmd.scan_cmp = 1'b1;
                    if (i_status.scan_last) begin
                        n_state = ucb1_pkg::S_OUT;
                    end else begin
                        o_cmd.scan_next = 1'b1;
                        n_state = ucb1_pkg::S_SCAN_RD;
                    end
                end
            end
            ucb1_pkg::S_OUT: begin
                o_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = ucb1_pkg::S_IDLE;
                end
            end
            default: n_state = ucb1_pkg::S_IDLE;
        endcase
    end

endmodule

@@ rtl/ucb1_div.sv @@
// ----------------------------------------------------------------------------
// UCB1 divider
// Unsigned 64 by 32 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ucb1_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic [63:0] o_quo,
    output logic        o_done
);

    logic [63:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [32:0] s_trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        s_trial = {r_rem[31:0], r_quo[63]};
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // shift one numerator bit in, subtract if it fits
            if (s_trial >= {1'b0, r_den}) begin
                n_rem = s_trial - {1'b0, r_den};
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = s_trial;
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_quo  = r_quo;
    assign o_done = !r_busy && !i_start;

endmodule

@@ rtl/ucb1_sqrt.sv @@
// ----------------------------------------------------------------------------
// UCB1 square root
// Bit-pair integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module ucb1_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic [31:0] o_root,
    output logic        o_done
);

    logic [63:0] r_val, n_val;
    logic [31:0] r_root, n_root;
    logic [34:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [34:0] s_trial;
    logic [34:0] s_sub;

    always_comb begin
        n_val  = r_val;
        n_root = r_root;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        s_trial = {r_rem[32:0], r_val[63:62]};
        s_sub   = {1'b0, r_root, 2'b01};
        if (i_start) begin
            n_val  = i_val;
            n_root = '0;
            n_rem  = '0;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_val = {r_val[61:0], 2'b00};
            if (s_trial >= s_sub) begin
                n_rem  = s_trial - s_sub;
                n_root = {r_root[30:0], 1'b1};
            end else begin
                n_rem  = s_trial;
                n_root = {r_root[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_val  <= n_val;
        r_root <= n_root;
        r_rem  <= n_rem;
    end

    assign o_root = r_root;
    assign o_done = !r_busy && !i_start;

endmodule

@@ rtl/ucb1_log.sv @@
// ----------------------------------------------------------------------------
// UCB1 log2 unit
// Q16.16 log2 of a 33-bit value by leading-one search and repeated squaring.
// ----------------------------------------------------------------------------
module ucb1_log (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_x,
    output logic [31:0] o_log,
    output logic        o_done
);

    logic [32:0] r_x, n_x;
    logic [5:0]  r_p, n_p;
    logic [32:0] r_y, n_y;
    logic [15:0] r_frac, n_frac;
    logic [4:0]  r_cnt, n_cnt;
    ucb1_pkg::t_log_phase r_ph, n_ph;
    logic [65:0] s_sq;
    logic [34:0] s_ysq;

    always_comb begin
        n_x    = r_x;
        n_p    = r_p;
        n_y    = r_y;
        n_frac = r_frac;
        n_cnt  = r_cnt;
        n_ph   = r_ph;
        s_sq   = r_y * r_y;
        s_ysq  = s_sq[65:31];
        if (i_start) begin
            n_x    = i_x;
            n_p    = 6'd32;
            n_frac = '0;
            n_ph   = ucb1_pkg::LOG_LZ;
        end else begin
            case (r_ph)
                ucb1_pkg::LOG_LZ: begin
                    // walk down to the leading one
                    if (r_x[r_p[5:0]] || r_p == 6'd0) begin
                        n_y   = 33'({r_x, 31'd0} >> r_p);
                        n_cnt = 5'd16;
                        n_ph  = ucb1_pkg::LOG_SQ;
                    end else begin
                        n_p = r_p - 6'd1;
                    end
                end
                ucb1_pkg::LOG_SQ: begin
                    n_frac = {r_frac[14:0], s_ysq[32] | s_ysq[33] | s_ysq[34]};
                    if (s_ysq >= 35'h1_0000_0000) begin
                        n_y = s_ysq[33:1];
                    end else begin
                        n_y = s_ysq[32:0];
                    end
                    n_cnt = r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        n_ph = ucb1_pkg::LOG_IDLE;
                    end
                end
                default: n_ph = ucb1_pkg::LOG_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= ucb1_pkg::LOG_IDLE;
            r_cnt <= '0;
        end else begin
            r_ph  <= n_ph;
            r_cnt <= n_cnt;
        end
        r_x    <= n_x;
        r_p    <= n_p;
        r_y    <= n_y;
        r_frac <= n_frac;
    end

    assign o_log  = {10'd0, r_p, r_frac};
    assign o_done = (r_ph == ucb1_pkg::LOG_IDLE) && !i_start;

endmodule

@@ rtl/ucb1_dp.sv @@
// ----------------------------------------------------------------------------
// UCB1 datapath
// Arm statistics, running total, divide/sqrt/log units and the arg-max.
// ----------------------------------------------------------------------------
module ucb1_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ucb1_pkg::t_cmd                    i_cmd,
    input  logic [31:0]                       i_reward,
    input  logic                              i_cfg_we,
    input  logic [4:0]                        i_cfg_data,
    output ucb1_pkg::t_status                 o_status,
    output logic [ucb1_pkg::ARM_BITS-1:0]     o_credited_arm,
    output logic [ucb1_pkg::ARM_BITS-1:0]     o_next_arm,
    output logic [63:0]                       o_cumulative_gain
);

    localparam int unsigned AB = ucb1_pkg::ARM_BITS;
    localparam int unsigned RB = ucb1_pkg::ROUND_BITS;

    logic signed [63:0] r_sum   [ucb1_pkg::ARMS];
    logic [31:0]        r_cnt   [ucb1_pkg::ARMS];
    logic signed [31:0] r_avg   [ucb1_pkg::ARMS];
    logic [4:0]         r_arms_in_use;
    logic [AB-1:0]      r_cur;
    logic [AB-1:0]      r_credited;
    logic [RB-1:0]      r_round;
    logic signed [63:0] r_total;
    logic signed [31:0] r_rew;
    logic               r_neg;
    logic               r_in_scan;
    logic [AB-1:0]      r_scan;
    logic [AB-1:0]      r_best;
    logic signed [63:0] r_best_score;
    logic               r_have;
    logic [63:0]        r_num;
    logic [31:0]        r_scan_cnt;
    logic signed [31:0] r_scan_avg;
    logic [4:0]         r_n;

    logic signed [63:0] s_rew64;
    logic signed [63:0] s_sum_add;
    logic signed [63:0] s_tot_add;
    logic [31:0]        s_new_cnt;
    logic [63:0]        s_abs_sum;
    logic [63:0]        s_div_num;
    logic [31:0]        s_div_den;
    logic [63:0]        s_quo;
    logic               s_div_done;
    logic [63:0]        s_mag;
    logic signed [31:0] s_avg;
    logic [31:0]        s_root;
    logic               s_sqrt_done;
    logic [31:0]        s_log;
    logic               s_log_done;
    logic [63:0]        s_ln_prod;
    logic signed [63:0] s_score;
    logic [RB-1:0]      s_round_inc;
    logic [RB:0]        s_log_x;
    logic [4:0]         s_n;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) begin
            sat_add = 64'sh7FFF_FFFF_FFFF_FFFF;
        end else if (a[63] && b[63] && !s[63]) begin
            sat_add = 64'sh8000_0000_0000_0000;
        end else begin
            sat_add = s;
        end
    endfunction

    assign s_rew64   = {{32{r_rew[31]}}, r_rew};
    assign s_sum_add = sat_add(r_sum[r_credited], s_rew64);
    assign s_tot_add = sat_add(r_total, {{32{i_reward[31]}}, i_reward});
    assign s_new_cnt = (r_cnt[r_credited] == 32'hFFFF_FFFF) ? r_cnt[r_credited]
                                                             : r_cnt[r_credited] + 32'd1;
    assign s_abs_sum = s_sum_add[63] ? 64'(-s_sum_add) : 64'(s_sum_add);

    // clamp arms in use to 1..ARMS
    always_comb begin
        if (r_arms_in_use == 5'd0) begin
            s_n = 5'd1;
        end else if (32'(r_arms_in_use) > ucb1_pkg::ARMS) begin
            s_n = 5'(ucb1_pkg::ARMS);
        end else begin
            s_n = r_arms_in_use;
        end
    end

    assign s_round_inc = (r_round == '1) ? r_round : r_round + 1'b1;
    assign s_log_x     = {1'b0, s_round_inc} + 33'd1;

    // share the divider between average update and bonus scoring
    assign s_div_num = r_in_scan ? r_num : s_abs_sum;
    assign s_div_den = r_in_scan ? r_scan_cnt : s_new_cnt;

    ucb1_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (s_div_num),
        .i_den   (s_div_den),
        .o_quo   (s_quo),
        .o_done  (s_div_done)
    );

    ucb1_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_val   ({s_quo[47:0], 16'd0}),
        .o_root  (s_root),
        .o_done  (s_sqrt_done)
    );

    ucb1_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.log_start),
        .i_x     (s_log_x),
        .o_log   (s_log),
        .o_done  (s_log_done)
    );

    assign s_ln_prod = s_log * ucb1_pkg::LN2_Q32;

    // signed average with clamp
    always_comb begin
        s_mag = s_quo;
        if (r_neg) begin
            s_avg = (s_mag > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-s_mag);
        end else begin
            s_avg = (s_mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(s_mag);
        end
    end

    assign s_score = 64'(r_scan_avg) + 64'(signed'({32'd0, s_root}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < ucb1_pkg::ARMS; a++) begin
                r_sum[a] <= '0;
                r_cnt[a] <= '0;
                r_avg[a] <= '0;
            end
            r_arms_in_use <= ucb1_pkg::ARMS_RESET;
            r_cur         <= '0;
            r_credited    <= '0;
            r_round       <= '0;
            r_total       <= '0;
            r_in_scan     <= 1'b0;
            r_scan        <= '0;
            r_best        <= '0;
            r_have        <= 1'b0;
            r_num         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_arms_in_use <= i_cfg_data;
            end
            if (i_cmd.start_upd) begin
                r_rew      <= i_reward;
                r_credited <= r_cur;
                r_total    <= s_tot_add;
                r_in_scan  <= 1'b0;
                r_n        <= s_n;
            end
            // write the new sum and count as the average divide starts
            if (i_cmd.div_start && !r_in_scan) begin
                r_sum[r_credited] <= s_sum_add;
                r_cnt[r_credited] <= s_new_cnt;
                r_neg             <= s_sum_add[63];
            end
            if (i_cmd.upd_wr) begin
                r_avg[r_credited] <= s_avg;
                r_round           <= s_round_inc;
                if (32'(s_round_inc) < 32'(r_n)) begin
                    r_cur <= AB'(s_round_inc);
                end
            end
            if (i_cmd.ln_calc) begin
                r_num <= {31'd0, s_ln_prod[63:32], 1'b0};
            end
            if (i_cmd.scan_init) begin
                r_in_scan <= 1'b1;
                r_scan    <= '0;
                r_have    <= 1'b0;
            end
            if (i_cmd.scan_rd) begin
                r_scan_cnt <= r_cnt[r_scan];
                r_scan_avg <= r_avg[r_scan];
            end
            if (i_cmd.pick_next) begin
                r_cur <= r_scan;
            end
            if (i_cmd.scan_cmp) begin
                if (!r_have || s_score > r_best_score) begin
                    r_have       <= 1'b1;
                    r_best_score <= s_score;
                    r_best       <= r_scan;
                    if (o_status.scan_last) begin
                        r_cur <= r_scan;
                    end
                end else if (o_status.scan_last) begin
                    r_cur <= r_best;
                end
            end
            if (i_cmd.scan_next) begin
                r_scan <= r_scan + 1'b1;
            end
        end
    end

    assign o_status.div_done   = s_div_done;
    assign o_status.sqrt_done  = s_sqrt_done;
    assign o_status.log_done   = s_log_done;
    assign o_status.explore    = 32'(s_round_inc) < 32'(r_n);
    assign o_status.count_zero = (r_scan_cnt == '0);
    assign o_status.scan_last  = (5'(r_scan) + 5'd1 >= r_n);

    assign o_credited_arm    = r_credited;
    assign o_next_arm        = r_cur;
    assign o_cumulative_gain = r_total;

endmodule

@@ rtl/ucb1_arm_selector_core.sv @@
// ----------------------------------------------------------------------------
// UCB1 arm selector core
// Credits each reward to the current arm and picks the next arm by UCB1.
// ----------------------------------------------------------------------------
// Sequence: during the exploration rounds the update goes straight to output;
//   afterwards a log2 step, then per scored arm a read, a divide and a root;
//   an unpulled arm ends the scan at once and is picked.
// Throughput: one transaction at a time; the next is accepted in the cycle
//   after the result leaves.
// Reset: synchronous active low; clears all arm statistics, the round index,
//   the running total and the current arm, and sets arms in use to 16.
module ucb1_arm_selector_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_reward,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_credited_arm,
    output logic [3:0]  o_next_arm,
    output logic [63:0] o_cumulative_gain
);

    ucb1_pkg::t_cmd    s_cmd;
    ucb1_pkg::t_status s_status;

    // sequence the work of one transaction
    ucb1_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_stall (i_stall),
        .i_status    (s_status),
        .o_cmd       (s_cmd),
        .o_stall     (o_stall),
        .o_valid     (o_valid)
    );

    // hold statistics and compute scores
    ucb1_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (s_cmd),
        .i_reward          (i_reward),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .o_status          (s_status),
        .o_credited_arm    (o_credited_arm),
        .o_next_arm        (o_next_arm),
        .o_cumulative_gain (o_cumulative_gain)
    );

endmodule
